// File: hdl/bsw_pkg.sv
// bsw_pkg: shared widths, latencies, register codes and types of the bezier warp core
// no dependencies
`default_nettype none
package bsw_pkg;

  localparam int WFRAC       = 16;          // fraction bits of u, v and weights
  localparam int QB          = WFRAC + 1;   // quotient bits of u and v, up to 1.0
  localparam int PT_W        = 18;          // control point width, Q3.14
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int COL_W       = 12;
  localparam int OUT_W       = 20;
  localparam int SUM_FRAC    = 46;
  localparam int SUM_W       = 56;
  localparam int NUM_POINTS  = 16;
  localparam int IDX_W       = 4;
  localparam int MAX_DIM_DEF = 4096;
  localparam int COORD_FRAC_DEF = 8;

  localparam int DIV_LAT  = QB;
  localparam int BERN_LAT = 3;
  localparam int MAC_LAT  = 3;   // products, then two adder levels

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  typedef logic [QB-1:0] wgt_t;
  typedef wgt_t [3:0] wvec_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [PT_W-1:0] pt_t;

  typedef struct packed {
    logic             vld;
    logic             pix;
    logic [IDX_W-1:0] idx;
    pt_t              px;
    pt_t              py;
  } meta_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    pt_t              x;
    pt_t              y;
  } ld_t;

endpackage
`default_nettype wire

// File: hdl/bsw_in_if.sv
// bsw_in_if: input channel, load and pixel beats
// depends on bsw_pkg
`default_nettype none
interface bsw_in_if;
  import bsw_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [IDX_W-1:0] point_index;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic [COL_W-1:0] dest_col;
  logic [COL_W-1:0] dest_row;
  modport source(output valid, action, point_index, point_x, point_y, dest_col, dest_row,
                 input ready);
  modport sink(input valid, action, point_index, point_x, point_y, dest_col, dest_row,
               output ready);
endinterface
`default_nettype wire

// File: hdl/bsw_out_if.sv
// bsw_out_if: result channel, mapped source coordinates
// depends on bsw_pkg
`default_nettype none
interface bsw_out_if;
  import bsw_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] source_x;
  logic [OUT_W-1:0] source_y;
  logic             outside;
  modport source(output valid, source_x, source_y, outside, input ready);
  modport sink(input valid, source_x, source_y, outside, output ready);
endinterface
`default_nettype wire

// File: hdl/bsw_cfg_if.sv
// bsw_cfg_if: register write channel
// depends on bsw_pkg
`default_nettype none
interface bsw_cfg_if;
  import bsw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/bsw_div.sv
// bsw_div: pipelined restoring divider, one quotient bit per stage
// depends on bsw_pkg
`default_nettype none
module bsw_div #(
  parameter int DW = 12
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [DW+bsw_pkg::QB-1:0]   num,
  input  wire logic [DW-1:0]               den,
  output      logic [bsw_pkg::QB-1:0]      quo
);
  import bsw_pkg::*;
  localparam int NW = DW + QB;

  logic [DW-1:0] rem_r [QB];
  logic [QB-1:0] q_r   [QB];
  logic [QB-1:0] low_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_st
    logic [DW-1:0] rin;
    logic [QB-1:0] lin;
    logic [QB-1:0] qin;
    logic [DW:0]   trial;
    if (k == 0) begin : g_first
      // top part of the numerator is already below the divisor
      assign rin = num[NW-1:QB];
      assign lin = num[QB-1:0];
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign lin = low_r[k-1];
      assign qin = q_r[k-1];
    end
    assign trial = {rin, lin[QB-1-k]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, den}) begin
          rem_r[k] <= DW'(trial - {1'b0, den});
          q_r[k]   <= {qin[QB-2:0], 1'b1};
        end else begin
          rem_r[k] <= trial[DW-1:0];
          q_r[k]   <= {qin[QB-2:0], 1'b0};
        end
        low_r[k] <= lin;
      end
    end
  end

  assign quo = q_r[QB-1];
endmodule
`default_nettype wire

// File: hdl/bsw_bern.sv
// bsw_bern: three-stage cubic bernstein weights of one coordinate
// depends on bsw_pkg
`default_nettype none
module bsw_bern (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire bsw_pkg::wgt_t  u,
  output      bsw_pkg::wvec_t w
);
  import bsw_pkg::*;
  localparam int PW = 2 * QB;
  localparam int CW = 50;
  localparam wgt_t ONE = wgt_t'(1) << WFRAC;
  localparam logic [CW-1:0] RND = CW'(1) << 31;

  wgt_t            u_r, t_r;
  logic [PW-1:0]   uu_r, tt_r, ut_r;
  logic [CW-1:0]   c_r [4];
  wvec_t           w_r;
  logic [PW+QB-1:0] p1, p2;

  always_ff @(posedge clk) begin
    if (en) begin
      u_r  <= u;
      t_r  <= ONE - u;
      uu_r <= u * u;
      tt_r <= (ONE - u) * (ONE - u);
      ut_r <= u * (ONE - u);
    end
  end

  assign p1 = ut_r * t_r;
  assign p2 = uu_r * t_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0] <= CW'(tt_r * t_r);
      c_r[1] <= CW'(p1) + (CW'(p1) << 1);
      c_r[2] <= CW'(p2) + (CW'(p2) << 1);
      c_r[3] <= CW'(uu_r * u_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        w_r[k] <= QB'((c_r[k] + RND) >> 32);
      end
    end
  end

  assign w = w_r;
endmodule
`default_nettype wire

// File: hdl/bsw_mac.sv
// bsw_mac: control point store, weight products and registered adder tree
// depends on bsw_pkg
`default_nettype none
module bsw_mac (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire bsw_pkg::wvec_t bu,
  input  wire bsw_pkg::wvec_t bv,
  input  wire bsw_pkg::ld_t   ld,
  output      bsw_pkg::sum_t  sum_x,
  output      bsw_pkg::sum_t  sum_y
);
  import bsw_pkg::*;
  localparam int WT_W = 2 * QB;

  logic [WT_W-1:0] wt_r [NUM_POINTS];
  pt_t  store_x_r [NUM_POINTS];
  pt_t  store_y_r [NUM_POINTS];
  sum_t term_x_r [NUM_POINTS];
  sum_t term_y_r [NUM_POINTS];
  sum_t part_x_r [4];
  sum_t part_y_r [4];
  sum_t sum_x_r, sum_y_r;

  // weight of point row i, column j is bu[j] * bv[i]
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_POINTS; k++) begin
        wt_r[k] <= bu[k % 4] * bv[k / 4];
      end
    end
  end

  // loads land at the same stage pixels read the store, so order is kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_POINTS; k++) begin
        store_x_r[k] <= '0;
        store_y_r[k] <= '0;
      end
    end else if (en && ld.we) begin
      store_x_r[ld.idx] <= ld.x;
      store_y_r[ld.idx] <= ld.y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_POINTS; k++) begin
        term_x_r[k] <= SUM_W'($signed({1'b0, wt_r[k]}) * store_x_r[k]);
        term_y_r[k] <= SUM_W'($signed({1'b0, wt_r[k]}) * store_y_r[k]);
      end
      for (int g = 0; g < 4; g++) begin
        part_x_r[g] <= term_x_r[4*g] + term_x_r[4*g+1] + term_x_r[4*g+2] + term_x_r[4*g+3];
        part_y_r[g] <= term_y_r[4*g] + term_y_r[4*g+1] + term_y_r[4*g+2] + term_y_r[4*g+3];
      end
      sum_x_r <= part_x_r[0] + part_x_r[1] + part_x_r[2] + part_x_r[3];
      sum_y_r <= part_y_r[0] + part_y_r[1] + part_y_r[2] + part_y_r[3];
    end
  end

  assign sum_x = sum_x_r;
  assign sum_y = sum_y_r;
endmodule
`default_nettype wire

// File: hdl/bezier_surface_warp_coords_core.sv
// Bicubic bezier warp core: every stage advances together, one beat per clock while the
// output is taken. A load beat writes control point (x, y) into a 16-entry store cleared
// by reset; a pixel beat forms u = col/(W-1), v = row/(H-1) in a 17-stage divider (one
// quotient bit per stage), then three stages of bernstein weights, one of weight
// products, one of point products and two adder levels, one of range test and scaling and
// the output register between accept and result.
// Points leaving the unit square come back with outside set and zero coordinates.
// Depends on bsw_pkg, the channel interfaces, bsw_div, bsw_bern and bsw_mac.
`default_nettype none
module bezier_surface_warp_coords_core #(
  parameter int MAX_DIM         = bsw_pkg::MAX_DIM_DEF,
  parameter int COORD_FRAC_BITS = bsw_pkg::COORD_FRAC_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bsw_in_if.sink     in_bus,
  bsw_out_if.source  out_bus,
  bsw_cfg_if.sink    cfg_bus
);
  import bsw_pkg::*;

  localparam int DW       = $clog2(MAX_DIM);
  localparam int NW       = DW + QB;
  localparam int META_LEN = DIV_LAT + BERN_LAT + 1 + MAC_LAT;
  localparam int STORE_STG = DIV_LAT + BERN_LAT;
  localparam int SH       = SUM_FRAC - COORD_FRAC_BITS;
  localparam int PW       = SUM_FRAC + 1 + DW;
  localparam sum_t SUM_ONE = sum_t'(1) <<< SUM_FRAC;
  localparam logic [PW:0] RND_S = (PW+1)'(1) << (SH - 1);
  localparam logic [PW:0] OUT_MAX = (PW+1)'({OUT_W{1'b1}});

  logic [CFG_W-1:0] width_r, height_r;
  logic [DW-1:0]    wm1, hm1, col_sat, row_sat;
  logic [NW-1:0]    num_u, num_v;
  logic             pipe_en;
  meta_t            meta_r [META_LEN];
  wgt_t             u_q, v_q;
  wvec_t            bu, bv;
  ld_t              ld;
  sum_t             sum_x, sum_y;

  logic             c1_vld_r, c1_out_r;
  logic [PW-1:0]    c1_px_r, c1_py_r;
  logic [PW:0]      rx, ry, rx_sh, ry_sh;
  logic             out_vld_r, out_vld_nxt, out_o_r;
  logic [OUT_W-1:0] out_x_r, out_y_r;

  // configuration
  assign cfg_bus.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(4096);
      height_r <= CFG_W'(4096);
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_bus.data;
        REG_IMAGE_HEIGHT: height_r <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  // saturated dimension minus one
  always_comb begin
    if (width_r < CFG_W'(2))            wm1 = DW'(1);
    else if (32'(width_r) > MAX_DIM)    wm1 = DW'(MAX_DIM - 1);
    else                                wm1 = DW'(width_r - 1'b1);
    if (height_r < CFG_W'(2))           hm1 = DW'(1);
    else if (32'(height_r) > MAX_DIM)   hm1 = DW'(MAX_DIM - 1);
    else                                hm1 = DW'(height_r - 1'b1);
  end

  assign col_sat = (32'(in_bus.dest_col) > 32'(wm1)) ? wm1 : DW'(in_bus.dest_col);
  assign row_sat = (32'(in_bus.dest_row) > 32'(hm1)) ? hm1 : DW'(in_bus.dest_row);
  assign num_u = NW'({col_sat, {WFRAC{1'b0}}}) + NW'(wm1 >> 1);
  assign num_v = NW'({row_sat, {WFRAC{1'b0}}}) + NW'(hm1 >> 1);

  assign pipe_en      = !out_vld_r || out_bus.ready;
  assign in_bus.ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < META_LEN; k++) meta_r[k] <= '0;
    end else if (pipe_en) begin
      meta_r[0].vld <= in_bus.valid;
      meta_r[0].pix <= in_bus.action;
      meta_r[0].idx <= in_bus.point_index;
      meta_r[0].px  <= in_bus.point_x;
      meta_r[0].py  <= in_bus.point_y;
      for (int k = 1; k < META_LEN; k++) meta_r[k] <= meta_r[k-1];
    end
  end

  bsw_div #(.DW(DW)) u_div_u (.clk, .en(pipe_en), .num(num_u), .den(wm1), .quo(u_q));
  bsw_div #(.DW(DW)) u_div_v (.clk, .en(pipe_en), .num(num_v), .den(hm1), .quo(v_q));

  bsw_bern u_bern_u (.clk, .en(pipe_en), .u(u_q), .w(bu));
  bsw_bern u_bern_v (.clk, .en(pipe_en), .u(v_q), .w(bv));

  assign ld.we  = meta_r[STORE_STG].vld && !meta_r[STORE_STG].pix;
  assign ld.idx = meta_r[STORE_STG].idx;
  assign ld.x   = meta_r[STORE_STG].px;
  assign ld.y   = meta_r[STORE_STG].py;

  bsw_mac u_mac (
    .clk, .rst_n, .en(pipe_en), .bu, .bv, .ld, .sum_x, .sum_y
  );

  // range test and scaling
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
    end else if (pipe_en) begin
      c1_vld_r <= meta_r[META_LEN-1].vld && meta_r[META_LEN-1].pix;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      c1_out_r <= sum_x[SUM_W-1] || sum_y[SUM_W-1] || (sum_x > SUM_ONE) || (sum_y > SUM_ONE);
      c1_px_r  <= sum_x[SUM_FRAC:0] * wm1;
      c1_py_r  <= sum_y[SUM_FRAC:0] * hm1;
    end
  end

  assign rx    = {1'b0, c1_px_r} + RND_S;
  assign ry    = {1'b0, c1_py_r} + RND_S;
  assign rx_sh = rx >> SH;
  assign ry_sh = ry >> SH;

  assign out_vld_nxt = pipe_en ? c1_vld_r : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_o_r <= c1_out_r;
      if (c1_out_r) begin
        out_x_r <= '0;
        out_y_r <= '0;
      end else begin
        out_x_r <= (rx_sh > OUT_MAX) ? {OUT_W{1'b1}} : OUT_W'(rx_sh);
        out_y_r <= (ry_sh > OUT_MAX) ? {OUT_W{1'b1}} : OUT_W'(ry_sh);
      end
    end
  end

  assign out_bus.valid    = out_vld_r;
  assign out_bus.source_x = out_x_r;
  assign out_bus.source_y = out_y_r;
  assign out_bus.outside  = out_o_r;

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_o_r |-> out_x_r == '0 && out_y_r == '0)
    else $error("outside result carries nonzero coordinates");

  a_stall_holds_meta: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(meta_r[STORE_STG]) && $stable(c1_vld_r))
    else $error("pipeline moved during a stall");

  a_result_from_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(c1_vld_r))
    else $error("result raised without a pixel beat");

endmodule
`default_nettype wire
